### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/lae_pkg.sv
package lae_pkg;

  localparam int CW    = 32;
  localparam int AW    = 32;
  localparam int ITER  = 30;
  localparam int GUARD = 48 - ((CW > 25) ? CW : 25);
  // Internal coordinate width: scaled input plus CORDIC growth headroom.
  localparam int DW    = CW + GUARD + 8;
  localparam int RW    = 24;
  localparam int IN_W  = 6 * CW + 2 * AW;
  localparam int OUT_W = 4 * CW + 2 * AW;

  localparam logic [29:0] INV_GAIN = 30'd652032874;
  localparam logic [31:0] QUARTER  = 32'h4000_0000;
  localparam logic [31:0] HALF     = 32'h8000_0000;
  localparam logic [RW-1:0] RADIUS_RESET = 24'd6523904;

  localparam logic [31:0] ATAN [ITER] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef logic signed [DW-1:0] val_t;
  typedef logic signed [33:0]   zacc_t;

  typedef struct packed {
    val_t        a;
    val_t        b;
    val_t        c;
    val_t        d;
    logic [31:0] ang;
  } side_t;

  function automatic logic [31:0] angle_in(input logic [AW-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    if (AW <= 32) t = t << ((32 - AW) & 63);
    else          t = t >> ((AW - 32) & 63);
    return t[31:0];
  endfunction

  function automatic logic [AW-1:0] angle_out(input logic [31:0] a);
    logic [63:0] t;
    if (AW < 32) begin
      t = (64'(a) + (64'd1 << ((31 - AW) & 63))) & 64'hFFFF_FFFF;
      t = t >> ((32 - AW) & 63);
    end else begin
      t = 64'(a) << ((AW - 32) & 63);
    end
    return t[AW-1:0];
  endfunction

  function automatic val_t scale_in(input logic signed [CW-1:0] v);
    val_t r;
    r = v;
    return r <<< GUARD;
  endfunction

  // Drops the guard bits with rounding, then clamps to the field range.
  function automatic logic [CW-1:0] sat_signed(input val_t v);
    val_t u;
    val_t lim;
    lim = val_t'(1) <<< (CW - 1);
    u = (v + (val_t'(1) <<< (GUARD - 1))) >>> GUARD;
    if (u > lim - 1) u = lim - 1;
    if (u < -lim)    u = -lim;
    return u[CW-1:0];
  endfunction

endpackage

### design/lae_gain.sv
module lae_gain import lae_pkg::*; (
  input  logic clk,
  input  logic en,
  input  val_t v,
  output val_t res
);

  logic        sgn;
  logic [59:0] q;
  logic [55:0] r;
  logic [DW-1:0] m;
  logic [56:0] low_sum;
  logic [DW-1:0] mag;

  assign m = (v < 0) ? DW'(-v) : DW'(v);

  always_ff @(posedge clk) begin
    if (en) begin
      sgn <= (v < 0);
      q   <= 60'(m[DW-1:26]) * 60'(INV_GAIN);
      r   <= 56'(m[25:0]) * 56'(INV_GAIN);
    end
  end

  always_comb begin
    low_sum = 57'({q[3:0], 26'd0}) + 57'(r) + (57'd1 << 29);
    mag     = DW'(q >> 4) + DW'(low_sum >> 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= sgn ? -val_t'(mag) : val_t'(mag);
    end
  end

endmodule

### design/lae_rot.sv
module lae_rot import lae_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  val_t        in_x,
  input  val_t        in_y,
  input  logic [31:0] in_ang,
  input  side_t       in_side,
  output logic        out_valid,
  output val_t        out_x,
  output val_t        out_y,
  output side_t       out_side
);

  logic  vld [ITER+1];
  val_t  x   [ITER+1];
  val_t  y   [ITER+1];
  zacc_t z   [ITER+1];
  side_t sd  [ITER+1];
  logic  vg1, vg2;
  side_t sg1, sg2;

  logic [1:0]  q;
  logic [31:0] sum;
  logic [31:0] resid;
  val_t        px, py;

  // Quadrant pre-rotation leaves a residual within one eighth of a turn.
  always_comb begin
    sum   = in_ang + 32'h2000_0000;
    q     = sum[31:30];
    resid = in_ang - {q, 30'd0};
    unique case (q)
      2'd0: begin px = in_x;  py = in_y;  end
      2'd1: begin px = -in_y; py = in_x;  end
      2'd2: begin px = -in_x; py = -in_y; end
      2'd3: begin px = in_y;  py = -in_x; end
      default: begin px = in_x; py = in_y; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ITER; i++) vld[i] <= 1'b0;
      vg1 <= 1'b0;
      vg2 <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 0; i < ITER; i++) vld[i+1] <= vld[i];
      vg1 <= vld[ITER];
      vg2 <= vg1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= px;
      y[0]  <= py;
      z[0]  <= zacc_t'(signed'(resid));
      sd[0] <= in_side;
      sg1   <= sd[ITER];
      sg2   <= sg1;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - zacc_t'(ATAN[i]);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + zacc_t'(ATAN[i]);
        end
        sd[i+1] <= sd[i];
      end
    end
  end

  lae_gain u_gx (.clk(clk), .en(en), .v(x[ITER]), .res(out_x));
  lae_gain u_gy (.clk(clk), .en(en), .v(y[ITER]), .res(out_y));

  assign out_valid = vg2;
  assign out_side  = sg2;

endmodule

### design/lae_vec.sv
module lae_vec import lae_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  val_t        in_x,
  input  val_t        in_y,
  input  side_t       in_side,
  output logic        out_valid,
  output val_t        out_mag,
  output logic [31:0] out_ang,
  output side_t       out_side
);

  logic        vld [ITER+1];
  logic        zf  [ITER+1];
  val_t        x   [ITER+1];
  val_t        y   [ITER+1];
  logic [31:0] z   [ITER+1];
  side_t       sd  [ITER+1];
  logic        vg1, vg2, zg1, zg2;
  logic [31:0] ag1, ag2;
  side_t       sg1, sg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ITER; i++) vld[i] <= 1'b0;
      vg1 <= 1'b0;
      vg2 <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 0; i < ITER; i++) vld[i+1] <= vld[i];
      vg1 <= vld[ITER];
      vg2 <= vg1;
    end
  end

  // A vector in the left half plane is flipped first and starts at half a turn.
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (in_x == 0) && (in_y == 0);
      if (in_x < 0) begin
        x[0] <= -in_x;
        y[0] <= -in_y;
        z[0] <= HALF;
      end else begin
        x[0] <= in_x;
        y[0] <= in_y;
        z[0] <= 32'd0;
      end
      sd[0] <= in_side;
      zg1   <= zf[ITER];
      zg2   <= zg1;
      ag1   <= z[ITER];
      ag2   <= zg1 ? 32'd0 : ag1;
      sg1   <= sd[ITER];
      sg2   <= sg1;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (y[i] < 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN[i];
        end
        zf[i+1] <= zf[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  lae_gain u_gm (.clk(clk), .en(en), .v(x[ITER]), .res(out_mag));

  assign out_valid = vg2;
  assign out_ang   = ag2;
  assign out_side  = sg2;

endmodule

### design/satellite_look_angle_engine.sv
// Channel  Signals                          Content
// s_       s_tvalid s_tready s_tdata        satellite state and station angles
// m_       m_tvalid m_tready m_tdata m_tuser range, look angles, velocities
// cfg_     cfg_valid cfg_ready cfg_data     station radius
//
// One item can be accepted every cycle unless a result waits with m_tready low.
// The pipeline is four CORDIC passes of 33 stages each (entry register, 30 steps and
// two gain stages) plus the input register, the station-frame register and the
// output register.
// Reset clears all valid bits and loads the default station radius.
// The whole pipeline holds while a result waits; nothing is lost or repeated.
module satellite_look_angle_engine import lae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // sat_x, sat_y, sat_z, sat_vx, sat_vy, sat_vz, station_lon, station_lat
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // slant_range, azimuth, elevation, vel_north, vel_up, vel_east
  output logic [OUT_W-1:0] m_tdata,
  // range_zero
  output logic [0:0]       m_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RW-1:0]    cfg_data
);

  logic        en;
  logic [RW-1:0] radius;

  logic        i_vld;
  val_t        i_x, i_y, i_z, i_vx, i_vy, i_vz;
  logic [31:0] i_nlon, i_nlat;

  logic  p1_vld, v1_vld, p2_vld, v2_vld;
  val_t  p1_x, p1_y, v1_x, v1_y, p2_x, p2_y, v2_x, v2_y;
  side_t p1_sd, v1_sd, p2_sd, v2_sd;

  logic  s_vld;
  val_t  s_up, s_north, s_east, s_vn, s_vu, s_ve;

  logic        az_vld, el_vld;
  val_t        az_mag, el_mag;
  logic [31:0] az_ang, el_ang;
  side_t       az_sd, el_sd;

  logic signed [31:0] es;
  val_t               rng;
  logic [CW-1:0]      rng_f;
  logic               zero;
  logic [AW-1:0]      el_f;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
      s_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      i_vld <= s_tvalid;
      s_vld <= p2_vld;
      m_tvalid <= el_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_x    <= scale_in(s_tdata[CW-1:0]);
      i_y    <= scale_in(s_tdata[2*CW-1:CW]);
      i_z    <= scale_in(s_tdata[3*CW-1:2*CW]);
      i_vx   <= scale_in(s_tdata[4*CW-1:3*CW]);
      i_vy   <= scale_in(s_tdata[5*CW-1:4*CW]);
      i_vz   <= scale_in(s_tdata[6*CW-1:5*CW]);
      i_nlon <= 32'd0 - angle_in(s_tdata[6*CW+AW-1:6*CW]);
      i_nlat <= 32'd0 - angle_in(s_tdata[6*CW+2*AW-1:6*CW+AW]);
    end
  end

  // Longitude turn: x toward the station meridian, y east.
  lae_rot u_rot_p1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(i_vld),
    .in_x(i_x), .in_y(i_y), .in_ang(i_nlon),
    .in_side('{a: i_z, b: '0, c: '0, d: '0, ang: i_nlat}),
    .out_valid(p1_vld), .out_x(p1_x), .out_y(p1_y), .out_side(p1_sd)
  );

  lae_rot u_rot_v1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(i_vld),
    .in_x(i_vx), .in_y(i_vy), .in_ang(i_nlon),
    .in_side('{a: i_vz, b: '0, c: '0, d: '0, ang: '0}),
    .out_valid(v1_vld), .out_x(v1_x), .out_y(v1_y), .out_side(v1_sd)
  );

  // Latitude turn: x up, y north.
  lae_rot u_rot_p2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(p1_vld),
    .in_x(p1_x), .in_y(p1_sd.a), .in_ang(p1_sd.ang),
    .in_side('{a: p1_y, b: '0, c: '0, d: '0, ang: '0}),
    .out_valid(p2_vld), .out_x(p2_x), .out_y(p2_y), .out_side(p2_sd)
  );

  lae_rot u_rot_v2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1_vld),
    .in_x(v1_x), .in_y(v1_sd.a), .in_ang(p1_sd.ang),
    .in_side('{a: v1_y, b: '0, c: '0, d: '0, ang: '0}),
    .out_valid(v2_vld), .out_x(v2_x), .out_y(v2_y), .out_side(v2_sd)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s_up    <= p2_x - (val_t'(DW'(radius)) <<< GUARD);
      s_north <= p2_y;
      s_east  <= p2_sd.a;
      s_vu    <= v2_x;
      s_vn    <= v2_y;
      s_ve    <= v2_sd.a;
    end
  end

  lae_vec u_vec_az (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_vld),
    .in_x(s_north), .in_y(s_east),
    .in_side('{a: s_up, b: s_vn, c: s_vu, d: s_ve, ang: '0}),
    .out_valid(az_vld), .out_mag(az_mag), .out_ang(az_ang), .out_side(az_sd)
  );

  lae_vec u_vec_el (
    .clk(clk), .rst(rst), .en(en), .in_valid(az_vld),
    .in_x(az_mag), .in_y(az_sd.a),
    .in_side('{a: '0, b: az_sd.b, c: az_sd.c, d: az_sd.d, ang: az_ang}),
    .out_valid(el_vld), .out_mag(el_mag), .out_ang(el_ang), .out_side(el_sd)
  );

  // The CORDIC residual can push elevation just past a quarter turn.
  always_comb begin
    es = signed'(el_ang);
    if (es > signed'(QUARTER))  es = signed'(QUARTER);
    if (es < -signed'(QUARTER)) es = -signed'(QUARTER);
    rng = (el_mag + (val_t'(1) <<< (GUARD - 1))) >>> GUARD;
    if (rng < 0) rng = '0;
    if (rng > (val_t'(1) <<< CW) - 1) rng = (val_t'(1) <<< CW) - 1;
    rng_f = rng[CW-1:0];
    zero  = (rng == 0);
    el_f  = zero ? '0 : angle_out(es);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {sat_signed(el_sd.d), sat_signed(el_sd.c), sat_signed(el_sd.b),
                  el_f, angle_out(el_sd.ang), rng_f};
      m_tuser <= zero;
    end
  end

endmodule

### design/lae_checker.sv
`include "assert_macros.svh"

module lae_checker import lae_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [0:0]       m_tuser
);

  `ASSERT_CLK(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
  `ASSERT_CLK(a_ready, s_tready == (!m_tvalid || m_tready), "input ready disagrees with output stall")
  `ASSERT_NEVER(a_zero_el, m_tvalid && m_tuser[0] && (m_tdata[2*CW+AW-1:CW+AW] != 0), "zero range with nonzero elevation")

endmodule

bind satellite_look_angle_engine lae_checker u_lae_checker (.*);
